@@ hw/rtl/fsat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsat_pkg
// Shared types and constants for the fragment send/ack tracker.
// ----------------------------------------------------------------------------
package fsat_pkg;

  localparam int MAX_FRAGMENTS = 127;
  localparam int FRAGMENT_BYTES = 1424;

  localparam int ID_W = 32;
  localparam int LEN_W = 21;
  localparam int FN_W = 8;
  localparam int CNT_W = 7;
  localparam int FLEN_W = 11;
  localparam int TRY_W = 8;

  localparam logic [LEN_W-1:0] LENGTH_LIMIT = LEN_W'(16383 * 127);
  localparam logic [LEN_W-1:0] MAX_MSG_LEN = LEN_W'(MAX_FRAGMENTS * FRAGMENT_BYTES);
  localparam logic [FLEN_W-1:0] FRAG_LEN = FLEN_W'(FRAGMENT_BYTES);

  // ceil(len / 1424) = ((len + 1423) >> 4) / 89, the divide by 89 done as a
  // multiply by ceil(2^20 / 89); exact for every length that fits the count.
  localparam int PRE_SHIFT = 4;
  localparam int RECIP_SHIFT = 20;
  localparam logic [13:0] RECIP_89 = 14'd11782;

  typedef enum logic [1:0] {
    CMD_NEW   = 2'd0,
    CMD_SENT  = 2'd1,
    CMD_ACKED = 2'd2,
    CMD_TRY   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [FN_W-1:0]   fn;
    logic [CNT_W-1:0]  count;
    logic              oversize;
  } item_t;

  typedef struct packed {
    logic              too_large;
    logic [TRY_W-1:0]  try_count;
    logic              unsent_is_last;
    logic [FLEN_W-1:0] unsent_length;
    logic              all_acked;
    logic              all_sent;
    logic              unacked_exists;
    logic [CNT_W-1:0]  first_unacked;
    logic              unsent_exists;
    logic [CNT_W-1:0]  first_unsent;
    logic [CNT_W-1:0]  fragment_total;
    logic [ID_W-1:0]   current_id;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/fsat_first_clear.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsat_first_clear
// Priority encoder: lowest fragment below the count whose mark is clear.
// ----------------------------------------------------------------------------
module fsat_first_clear
  import fsat_pkg::*;
(
  input  wire logic [MAX_FRAGMENTS-1:0] marks,
  input  wire logic [CNT_W-1:0]         count,
  output logic      [CNT_W-1:0]         index,
  output logic                          found
);

  always_comb begin
    index = '0;
    found = 1'b0;
    for (int i = MAX_FRAGMENTS - 1; i >= 0; i--) begin
      if (!marks[i] && (CNT_W'(i) < count)) begin
        index = CNT_W'(i);
        found = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fsat_ingress.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsat_ingress
// Input register; works out fragment count and oversize flag on the way in.
// ----------------------------------------------------------------------------
module fsat_ingress
  import fsat_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cmd_t             in_cmd,
  input  wire logic [ID_W-1:0]  in_id,
  input  wire logic [LEN_W-1:0] in_len,
  input  wire logic [FN_W-1:0]  in_fn,
  output logic                  item_valid,
  input  wire logic             item_ready,
  output item_t                 item
);

  logic [LEN_W:0]           rounded;
  logic [LEN_W-PRE_SHIFT:0] scaled;
  logic [31:0]              product;
  item_t                    item_next;

  always_comb begin
    rounded = {1'b0, in_len} + (LEN_W+1)'(FRAGMENT_BYTES - 1);
    scaled = rounded[LEN_W:PRE_SHIFT];
    product = 32'(scaled) * 32'(RECIP_89);
    item_next.cmd = in_cmd;
    item_next.id = in_id;
    item_next.len = in_len;
    item_next.fn = in_fn;
    item_next.oversize = (in_len > LENGTH_LIMIT) || (in_len > MAX_MSG_LEN);
    item_next.count = item_next.oversize ? '0 : product[RECIP_SHIFT +: CNT_W];
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fsat_track.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsat_track
// Message state and bitmaps; applies one item and registers its result.
// ----------------------------------------------------------------------------
module fsat_track
  import fsat_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_ready,
  input  wire item_t item,
  output logic       res_valid,
  input  wire logic  res_ready,
  output result_t    res
);

  logic [MAX_FRAGMENTS-1:0] sent;
  logic [MAX_FRAGMENTS-1:0] acked;
  logic [ID_W-1:0]          held_id;
  logic [CNT_W-1:0]         held_count;
  logic [FLEN_W-1:0]        held_last;
  logic [TRY_W-1:0]         tries;
  logic                     oversize;

  logic [MAX_FRAGMENTS-1:0] sent_next;
  logic [MAX_FRAGMENTS-1:0] acked_next;
  logic [ID_W-1:0]          held_id_next;
  logic [CNT_W-1:0]         held_count_next;
  logic [FLEN_W-1:0]        held_last_next;
  logic [TRY_W-1:0]         tries_next;
  logic                     oversize_next;

  logic              take;
  logic              fn_ok;
  logic [CNT_W-1:0]  count_m1;
  logic [LEN_W-1:0]  full_bytes;
  logic [CNT_W-1:0]  unsent_idx;
  logic              unsent_found;
  logic [CNT_W-1:0]  unacked_idx;
  logic              unacked_found;
  logic              is_last;
  result_t           res_next;

  assign item_ready = !res_valid || res_ready;
  assign take = item_valid && item_ready;

  always_comb begin
    sent_next = sent;
    acked_next = acked;
    held_id_next = held_id;
    held_count_next = held_count;
    held_last_next = held_last;
    tries_next = tries;
    oversize_next = oversize;
    fn_ok = item.fn < {1'b0, held_count};
    count_m1 = item.count - CNT_W'(1);
    full_bytes = LEN_W'(count_m1) * LEN_W'(FRAGMENT_BYTES);
    case (item.cmd)
      CMD_NEW: begin
        sent_next = '0;
        acked_next = '0;
        held_id_next = item.id;
        held_count_next = item.count;
        held_last_next = FLEN_W'(item.len - full_bytes);
        tries_next = '0;
        oversize_next = item.oversize;
      end
      CMD_SENT: begin
        if (fn_ok) begin
          sent_next[item.fn[CNT_W-1:0]] = 1'b1;
        end
      end
      CMD_ACKED: begin
        if (fn_ok) begin
          acked_next[item.fn[CNT_W-1:0]] = 1'b1;
        end
      end
      CMD_TRY: begin
        tries_next = tries + TRY_W'(1);
      end
      default: begin
      end
    endcase
  end

  fsat_first_clear u_unsent (
    .marks (sent_next),
    .count (held_count_next),
    .index (unsent_idx),
    .found (unsent_found)
  );

  fsat_first_clear u_unacked (
    .marks (acked_next),
    .count (held_count_next),
    .index (unacked_idx),
    .found (unacked_found)
  );

  always_comb begin
    is_last = unsent_found && ((unsent_idx + CNT_W'(1)) == held_count_next);
    res_next.current_id = held_id_next;
    res_next.fragment_total = held_count_next;
    res_next.first_unsent = unsent_idx;
    res_next.unsent_exists = unsent_found;
    res_next.first_unacked = unacked_idx;
    res_next.unacked_exists = unacked_found;
    res_next.all_sent = !unsent_found;
    res_next.all_acked = !unacked_found;
    res_next.unsent_is_last = is_last;
    res_next.try_count = tries_next;
    res_next.too_large = oversize_next;
    if (!unsent_found) begin
      res_next.unsent_length = '0;
    end else if (is_last) begin
      res_next.unsent_length = held_last_next;
    end else begin
      res_next.unsent_length = FRAG_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= '0;
      acked <= '0;
      held_id <= '0;
      held_count <= '0;
      held_last <= '0;
      tries <= '0;
      oversize <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        sent <= sent_next;
        acked <= acked_next;
        held_id <= held_id_next;
        held_count <= held_count_next;
        held_last <= held_last_next;
        tries <= tries_next;
        oversize <= oversize_next;
      end
      if (item_ready) begin
        res_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fragment_send_ack_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fragment_send_ack_tracker
// Send/ack bitmap tracking for one outbound message cut into 1424-byte
// fragments; one status transfer out for every command transfer in.
//
//   channel  dir  width        contents
//   s_*      in   64 + 2 user  command item
//   m_*      out  80           status after the command
//
// One transfer per cycle sustained while m_tready stays high; an input passes
// the input register, then state update, bitmap encoders and result register.
// rst is synchronous and clears both bitmaps, the message state and all
// valid flags. Backpressure on m_tready stalls the result register, then
// the input register, then s_tready.
// ----------------------------------------------------------------------------
module fragment_send_ack_tracker
  import fsat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [31:0] message_id, [52:32] message_length, [60:53] fragment_number
  input  wire logic [63:0] s_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [31:0] current_id, [38:32] fragment_total, [45:39] first_unsent,
  // [46] unsent_exists, [53:47] first_unacked, [54] unacked_exists,
  // [55] all_sent, [56] all_acked, [67:57] unsent_length,
  // [68] unsent_is_last, [76:69] try_count, [77] too_large
  output logic [79:0]      m_tdata
);

  logic    item_valid;
  logic    item_ready;
  item_t   item;
  result_t res;

  fsat_ingress u_ingress (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_cmd     (cmd_t'(s_tuser)),
    .in_id      (s_tdata[31:0]),
    .in_len     (s_tdata[52:32]),
    .in_fn      (s_tdata[60:53]),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  fsat_track u_track (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {2'b00, res};

endmodule
`default_nettype wire
